>>> design/arf_pkg.sv
// arf_pkg: shared types and constants of the advertising report filter
// no dependencies; imported by every module of the filter

package arf_pkg;

  localparam int KEY_W   = 56;
  localparam int TIME_W  = 48;
  localparam int QUEUE_DEPTH = 2;

  // register indexes of the configuration port
  localparam logic [7:0] CFG_MIN_SIGNAL = 8'd0;
  localparam logic [7:0] CFG_INTERVAL   = 8'd1;
  localparam logic [7:0] CFG_TYPE_MASK  = 8'd2;

  localparam logic signed [7:0] MIN_SIGNAL_RESET = -8'sd75;
  localparam logic [31:0]       INTERVAL_RESET   = 32'd10000;
  localparam logic [7:0]        TYPE_MASK_RESET  = 8'd3;

  typedef enum logic [2:0] {
    VERDICT_ACCEPTED  = 3'd0,
    VERDICT_BUSY      = 3'd1,
    VERDICT_NOT_CONN  = 3'd2,
    VERDICT_WEAK      = 3'd3,
    VERDICT_RECENT    = 3'd4
  } verdict_e;

  typedef struct packed {
    logic signed [7:0] min_signal;
    logic [31:0]       interval;
    logic [7:0]        type_mask;
  } cfg_t;

  // a classified report; accepted here means it still needs the table lookup
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    verdict_e          verdict;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> design/arf_front.sv
// arf_front: accepts reports and runs the busy, type and signal checks
// depends on arf_pkg; pushes classified items into arf_queue

module arf_front import arf_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [47:0]       device_address_i,
  input  logic [7:0]        address_kind_i,
  input  logic signed [7:0] signal_dbm_i,
  input  logic [2:0]        advert_kind_i,
  input  logic              link_busy_i,
  input  logic [47:0]       now_ms_i,
  input  cfg_t              cfg_i,
  input  q_status_t         q_status_i,
  output logic              push_o,
  output item_t             item_o
);

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    item_o.key = {address_kind_i, device_address_i};
    item_o.now = now_ms_i;
    if (link_busy_i) begin
      item_o.verdict = VERDICT_BUSY;
    end else if (!cfg_i.type_mask[advert_kind_i]) begin
      item_o.verdict = VERDICT_NOT_CONN;
    end else if (signal_dbm_i < cfg_i.min_signal) begin
      item_o.verdict = VERDICT_WEAK;
    end else begin
      item_o.verdict = VERDICT_ACCEPTED;
    end
  end

endmodule

>>> design/arf_queue.sv
// arf_queue: short fifo of classified items between front and back
// depends on arf_pkg

module arf_queue import arf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     item_i,
  input  logic      pop_i,
  output item_t     head_o,
  output q_status_t status_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t            slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;

  assign head_o         = slot_q[rd_ptr_q];
  assign status_o.full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> design/arf_back.sv
// arf_back: table lookup, refresh, fill and oldest-entry replacement
// depends on arf_pkg; pops items from arf_queue and drives the result register

module arf_back import arf_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  item_t       head_i,
  input  q_status_t   q_status_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  verdict_o,
  output logic [2:0]  slot_used_o,
  output logic        was_known_o,
  output logic        evicted_o
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
  logic [TIME_W-1:0] time_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  rd_key_q;
  logic [TIME_W-1:0] rd_time_q;

  logic              state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  old_idx_q, old_idx_d;
  logic [TIME_W-1:0] old_time_q, old_time_d;
  item_t             cur_q, cur_d;

  logic              out_valid_q, out_valid_d;
  verdict_e          verdict_q, verdict_d;
  logic [2:0]        slot_q, slot_d;
  logic              known_q, known_d;
  logic              evict_q, evict_d;

  logic              load_out;
  logic              out_free;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_key_en, wr_time_en;
  logic [KEY_W-1:0]  wr_key;
  logic [TIME_W-1:0] wr_time;
  logic [IDX_W-1:0]  slot_idx;
  logic [IDX_W+2:0]  slot_wide;

  logic              key_match, recent, take_old, last_entry, table_full;
  logic [TIME_W:0]   diff;
  logic [FILL_W-1:0] idx_inc;
  logic [IDX_W-1:0]  stalest_idx;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign key_match  = (rd_key_q == cur_q.key);
  assign diff       = {1'b0, cur_q.now} - {1'b0, rd_time_q};
  // time going backwards counts as zero elapsed
  assign recent     = diff[TIME_W] ? (cfg_i.interval != '0)
                                   : (diff[TIME_W-1:0] < {16'b0, cfg_i.interval});
  assign take_old   = (idx_q == '0) || (rd_time_q < old_time_q);
  assign stalest_idx = take_old ? idx_q : old_idx_q;
  assign idx_inc    = FILL_W'(idx_q) + FILL_W'(1);
  assign last_entry = (idx_inc == fill_q);
  assign table_full = (fill_q == FILL_W'(TABLE_DEPTH));
  assign slot_wide  = {3'b000, slot_idx};

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    old_idx_d  = old_idx_q;
    old_time_d = old_time_q;
    cur_d      = cur_q;
    pop_o      = 1'b0;
    load_out   = 1'b0;
    rd_addr    = '0;
    wr_addr    = '0;
    wr_key_en  = 1'b0;
    wr_time_en = 1'b0;
    wr_key     = cur_q.key;
    wr_time    = cur_q.now;
    slot_idx   = '0;
    verdict_d  = VERDICT_ACCEPTED;
    known_d    = 1'b0;
    evict_d    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!q_status_i.empty && out_free) begin
          pop_o = 1'b1;
          if (head_i.verdict != VERDICT_ACCEPTED) begin
            load_out  = 1'b1;
            verdict_d = head_i.verdict;
          end else if (fill_q == '0) begin
            // empty table: first entry goes straight into slot zero
            wr_key_en  = 1'b1;
            wr_time_en = 1'b1;
            wr_key     = head_i.key;
            wr_time    = head_i.now;
            fill_d     = FILL_W'(1);
            load_out   = 1'b1;
          end else begin
            cur_d   = head_i;
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (key_match) begin
          load_out = 1'b1;
          known_d  = 1'b1;
          state_d  = S_IDLE;
          if (recent) begin
            verdict_d = VERDICT_RECENT;
          end else begin
            wr_time_en = 1'b1;
            wr_addr    = idx_q;
            slot_idx   = idx_q;
          end
        end else begin
          old_idx_d = stalest_idx;
          if (take_old) begin
            old_time_d = rd_time_q;
          end
          if (last_entry) begin
            load_out   = 1'b1;
            wr_key_en  = 1'b1;
            wr_time_en = 1'b1;
            state_d    = S_IDLE;
            if (!table_full) begin
              wr_addr  = IDX_W'(fill_q);
              slot_idx = IDX_W'(fill_q);
              fill_d   = fill_q + FILL_W'(1);
            end else begin
              wr_addr  = stalest_idx;
              slot_idx = stalest_idx;
              evict_d  = 1'b1;
            end
          end else begin
            idx_d   = IDX_W'(idx_inc);
            rd_addr = IDX_W'(idx_inc);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    slot_d = slot_wide[2:0];
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    old_idx_q  <= old_idx_d;
    old_time_q <= old_time_d;
    cur_q      <= cur_d;
    if (load_out) begin
      verdict_q <= verdict_d;
      slot_q    <= slot_d;
      known_q   <= known_d;
      evict_q   <= evict_d;
    end
  end

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_time_en) begin
      time_mem[wr_addr] <= wr_time;
    end
    rd_key_q  <= key_mem[rd_addr];
    rd_time_q <= time_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign slot_used_o = slot_q;
  assign was_known_o = known_q;
  assign evicted_o   = evict_q;

endmodule

>>> design/adv_report_duplicate_filter.sv
// adv_report_duplicate_filter: top level of the timed duplicate filter
// depends on arf_pkg, arf_front, arf_queue and arf_back
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_stall_o  device_address..now_ms
//   out       output     out_valid_o/out_stall_i verdict, slot_used, was_known, evicted
//   cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a report dropped by the busy, type or signal check goes from the queue straight into the result register
// a report that reaches the table is scanned entry by entry: the back end reads
// one table entry per cycle from its memory port; a key match ends the scan early
// the front keeps accepting into a two-entry queue while the back end works
// reset empties the table (fill count zero) and loads the register defaults
// out_stall_i holds the result register; in_stall_o rises only when the queue is full

module adv_report_duplicate_filter import arf_pkg::*; #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [47:0]       device_address_i,
  input  logic [7:0]        address_kind_i,
  input  logic signed [7:0] signal_dbm_i,
  input  logic [2:0]        advert_kind_i,
  input  logic              link_busy_i,
  input  logic [47:0]       now_ms_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        verdict_o,
  output logic [2:0]        slot_used_o,
  output logic              was_known_o,
  output logic              evicted_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  cfg_t      cfg_q;
  q_status_t q_status;
  item_t     push_item;
  item_t     head_item;
  logic      q_push;
  logic      q_pop;

  assign cfg_ready_o = 1'b1;

  // writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_signal <= MIN_SIGNAL_RESET;
      cfg_q.interval   <= INTERVAL_RESET;
      cfg_q.type_mask  <= TYPE_MASK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MIN_SIGNAL: cfg_q.min_signal <= $signed(cfg_data_i[7:0]);
        CFG_INTERVAL:   cfg_q.interval   <= cfg_data_i;
        CFG_TYPE_MASK:  cfg_q.type_mask  <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  arf_front u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .device_address_i (device_address_i),
    .address_kind_i   (address_kind_i),
    .signal_dbm_i     (signal_dbm_i),
    .advert_kind_i    (advert_kind_i),
    .link_busy_i      (link_busy_i),
    .now_ms_i         (now_ms_i),
    .cfg_i            (cfg_q),
    .q_status_i       (q_status),
    .push_o           (q_push),
    .item_o           (push_item)
  );

  arf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .item_i   (push_item),
    .pop_i    (q_pop),
    .head_o   (head_item),
    .status_o (q_status)
  );

  arf_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head_item),
    .q_status_i  (q_status),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict_o),
    .slot_used_o (slot_used_o),
    .was_known_o (was_known_o),
    .evicted_o   (evicted_o)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("queue popped while empty");

  a_drop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o != VERDICT_ACCEPTED) |-> (slot_used_o == 3'd0) && !evicted_o)
    else $error("dropped report carries a slot or eviction");

  a_early_drop_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((verdict_o == VERDICT_BUSY) || (verdict_o == VERDICT_NOT_CONN) ||
      (verdict_o == VERDICT_WEAK)) |-> !was_known_o)
    else $error("early drop marked as known");

  a_known_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(was_known_o && evicted_o))
    else $error("known address reported as eviction");
`endif

endmodule

>>> sim/tb_adv_report_duplicate_filter.sv
// tb_adv_report_duplicate_filter: self-checking testbench of the duplicate filter
// a scoreboard class keeps its own copy of the table and the registers
// depends on arf_pkg and adv_report_duplicate_filter

`timescale 1ns / 100ps

module tb_adv_report_duplicate_filter import arf_pkg::*;;

  localparam int          DEPTH            = 8;
  localparam int          KEY_POOL         = 12;
  localparam int          CYCLE_LIMIT      = 600000;
  localparam logic [7:0]  FIRST_UNUSED_REG = CFG_TYPE_MASK + 8'd1;
  localparam logic [47:0] TIME_MAX         = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    verdict_e   verdict;
    logic [2:0] slot;
    logic       known;
    logic       evicted;
  } filter_outcome_t;

  class report_filter_model;
    logic [KEY_W-1:0]  slot_key [DEPTH];
    logic [TIME_W-1:0] slot_time [DEPTH];
    int                filled;
    logic signed [7:0] min_signal;
    logic [31:0]       interval;
    logic [7:0]        type_mask;
    filter_outcome_t   awaited_outcomes [$];
    int                errors;

    function new();
      foreach (slot_key[i]) begin
        slot_key[i]  = '0;
        slot_time[i] = '0;
      end
      filled     = 0;
      min_signal = MIN_SIGNAL_RESET;
      interval   = INTERVAL_RESET;
      type_mask  = TYPE_MASK_RESET;
      errors     = 0;
    endfunction

    function void write_register(logic [7:0] index, logic [31:0] data);
      case (index)
        CFG_MIN_SIGNAL: min_signal = data[7:0];
        CFG_INTERVAL:   interval   = data;
        CFG_TYPE_MASK:  type_mask  = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_report(logic [47:0] address, logic [7:0] kind,
                              logic signed [7:0] strength, logic [2:0] adv,
                              logic busy, logic [47:0] now);
      filter_outcome_t   res;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] elapsed;
      int                hit;
      int                oldest;
      res.verdict = VERDICT_ACCEPTED;
      res.slot    = '0;
      res.known   = 1'b0;
      res.evicted = 1'b0;
      key = {kind, address};
      hit = -1;
      if (busy) begin
        res.verdict = VERDICT_BUSY;
      end else if (!type_mask[adv]) begin
        res.verdict = VERDICT_NOT_CONN;
      end else if (strength < min_signal) begin
        res.verdict = VERDICT_WEAK;
      end else begin
        for (int i = 0; i < filled; i++) begin
          if (hit < 0 && slot_key[i] == key) hit = i;
        end
        if (hit >= 0) begin
          res.known = 1'b1;
          // time going backwards counts as no time elapsed
          elapsed = (now >= slot_time[hit]) ? now - slot_time[hit] : '0;
          if (elapsed < TIME_W'(interval)) begin
            res.verdict = VERDICT_RECENT;
          end else begin
            slot_time[hit] = now;
            res.slot = 3'(hit);
          end
        end else if (filled < DEPTH) begin
          slot_key[filled]  = key;
          slot_time[filled] = now;
          res.slot = 3'(filled);
          filled++;
        end else begin
          // strict compare keeps the lowest index among equal times
          oldest = 0;
          for (int i = 1; i < DEPTH; i++) begin
            if (slot_time[i] < slot_time[oldest]) oldest = i;
          end
          slot_key[oldest]  = key;
          slot_time[oldest] = now;
          res.slot    = 3'(oldest);
          res.evicted = 1'b1;
        end
      end
      awaited_outcomes.push_back(res);
    endfunction

    function void check_result(logic [2:0] verdict, logic [2:0] slot, logic known,
                               logic evicted);
      filter_outcome_t exp_res;
      if (awaited_outcomes.size() == 0) begin
        $error("result with no report outstanding: verdict %0d slot %0d", verdict, slot);
        errors++;
        return;
      end
      exp_res = awaited_outcomes.pop_front();
      if (verdict !== exp_res.verdict) begin
        $error("verdict: expected %0d, actual %0d", exp_res.verdict, verdict);
        errors++;
      end
      if (slot !== exp_res.slot) begin
        $error("slot_used: expected %0d, actual %0d", exp_res.slot, slot);
        errors++;
      end
      if (known !== exp_res.known) begin
        $error("was_known: expected %0d, actual %0d", exp_res.known, known);
        errors++;
      end
      if (evicted !== exp_res.evicted) begin
        $error("evicted: expected %0d, actual %0d", exp_res.evicted, evicted);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited_outcomes.size();
    endfunction
  endclass

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic [47:0]       device_address_i = '0;
  logic [7:0]        address_kind_i   = '0;
  logic signed [7:0] signal_dbm_i     = '0;
  logic [2:0]        advert_kind_i    = '0;
  logic              link_busy_i      = 1'b0;
  logic [47:0]       now_ms_i         = '0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [2:0]        verdict_o;
  logic [2:0]        slot_used_o;
  logic              was_known_o;
  logic              evicted_o;
  logic              cfg_valid_i      = 1'b0;
  logic              cfg_ready_o;
  logic [7:0]        cfg_index_i      = '0;
  logic [31:0]       cfg_data_i       = '0;

  report_filter_model sb;
  logic [47:0]        pool_addr [KEY_POOL];
  logic [7:0]         pool_kind [KEY_POOL];
  logic [47:0]        clock_ms;

  adv_report_duplicate_filter #(.TABLE_DEPTH(DEPTH)) dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  // result check first: a result at this edge belongs to an earlier transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result(verdict_o, slot_used_o, was_known_o, evicted_o);
      if (in_valid_i && !in_stall_o)
        sb.note_report(device_address_i, address_kind_i, signal_dbm_i, advert_kind_i,
                       link_busy_i, now_ms_i);
    end
  end

  // receiver stall: short bursts mostly, some long stalls and long free stretches
  initial begin
    int hold;
    int pick;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_stall_i <= 1'b0;
          hold = $urandom_range(0, 3);
        end else if (pick < 80) begin
          out_stall_i <= 1'b1;
          hold = $urandom_range(0, 2);
        end else if (pick < 95) begin
          out_stall_i <= 1'b0;
          hold = $urandom_range(20, 200);
        end else begin
          out_stall_i <= 1'b1;
          hold = $urandom_range(10, 40);
        end
      end else begin
        hold--;
      end
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_report(input logic [47:0] address, input logic [7:0] kind,
                             input logic signed [7:0] strength, input logic [2:0] adv,
                             input logic busy, input logic [47:0] now, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    device_address_i <= address;
    address_kind_i   <= kind;
    signal_dbm_i     <= strength;
    advert_kind_i    <= adv;
    link_busy_i      <= busy;
    now_ms_i         <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (2 * DEPTH + 4) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [7:0] index, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_register(index, data);
  endtask

  task automatic configure(input logic signed [7:0] min_dbm, input logic [31:0] interval,
                           input logic [7:0] mask);
    write_register(CFG_MIN_SIGNAL, {24'($urandom), min_dbm});
    write_register(CFG_INTERVAL, interval);
    write_register(CFG_TYPE_MASK, {24'($urandom), mask});
    write_register(8'($urandom_range(FIRST_UNUSED_REG, 255)), $urandom);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly reports that pass the early checks, drawn from a small key pool
  task automatic send_random_report(input bit gaps_on);
    logic [47:0]       address;
    logic [7:0]        kind;
    logic signed [7:0] strength;
    logic [2:0]        adv;
    logic              busy;
    int                pick;
    int                floor_dbm;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      pick    = $urandom_range(0, KEY_POOL - 1);
      address = pool_addr[pick];
      kind    = pool_kind[pick];
    end else begin
      address = {16'($urandom), $urandom};
      kind    = 8'($urandom);
    end
    busy = ($urandom_range(0, 11) == 0);
    if (sb.type_mask != 8'h00 && $urandom_range(0, 99) < 85) begin
      do adv = 3'($urandom); while (!sb.type_mask[adv]);
    end else begin
      adv = 3'($urandom);
    end
    if ($urandom_range(0, 99) < 85) begin
      floor_dbm = sb.min_signal;
      strength  = 8'(floor_dbm + int'($urandom_range(0, 127 - floor_dbm)));
    end else begin
      strength = 8'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 30)
      clock_ms += $urandom_range(0, 2);
    else if (pick < 90)
      clock_ms += $urandom_range(0, sb.interval / 4 + 1);
    else if (pick < 96)
      clock_ms = (clock_ms > 48'd40) ? clock_ms - $urandom_range(1, 40) : '0;
    else
      clock_ms += {16'($urandom_range(0, 3)), $urandom};
    send_report(address, kind, strength, adv, busy, clock_ms, gaps_on ? pick_gap() : 0);
  endtask

  initial begin
    logic signed [7:0] min_dbm;
    logic [31:0]       interval;
    logic [7:0]        mask;
    int                count;
    sb = new();
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_addr[i] = {16'($urandom), $urandom};
      pool_kind[i] = 8'($urandom);
    end
    // two keys that differ only in the address type
    pool_addr[1] = pool_addr[0];
    pool_kind[1] = pool_kind[0] ^ 8'h01;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part on the reset register values
    send_report(TIME_MAX, 8'hFF, 8'sd127, 3'd0, 1'b1, 48'd0, 0);
    send_report(pool_addr[0], pool_kind[0], 8'sd127, 3'd2, 1'b0, 48'd0, 0);
    send_report(pool_addr[0], pool_kind[0], -8'sd76, 3'd1, 1'b0, 48'd0, 0);
    send_report(48'd0, 8'h00, -8'sd75, 3'd0, 1'b0, 48'd0, 0);
    send_report(pool_addr[0], pool_kind[0], -8'sd128, 3'd0, 1'b0, 48'd0, 0);
    for (int i = 0; i < DEPTH - 1; i++)
      send_report(pool_addr[i], pool_kind[i], 8'sd127, 3'(i % 2), 1'b0, 48'd5, 0);
    // table full: first new key replaces the oldest, the next one hits a tie
    send_report(TIME_MAX, 8'hFF, 8'sd0, 3'd1, 1'b0, 48'd5, 0);
    send_report(pool_addr[7], pool_kind[7], 8'sd10, 3'd0, 1'b0, 48'd6, 0);
    send_report(pool_addr[0], pool_kind[0], 8'sd20, 3'd1, 1'b0, 48'd100, 0);
    send_report(pool_addr[0], pool_kind[0], 8'sd20, 3'd1, 1'b0, 48'd10005, 0);
    send_report(pool_addr[1], pool_kind[1], 8'sd20, 3'd0, 1'b0, 48'd3, 0);
    send_report(pool_addr[1], pool_kind[1], 8'sd20, 3'd0, 1'b0, 48'd10004, 0);
    send_report(pool_addr[1], pool_kind[1], 8'sd20, 3'd0, 1'b0, 48'd10005, 0);
    send_report(pool_addr[2], pool_kind[2], 8'sd20, 3'd0, 1'b0, TIME_MAX, 0);
    send_report(pool_addr[1], pool_kind[1], 8'sd20, 3'd0, 1'b0, TIME_MAX, 0);
    wait_until_drained();
    configure(MIN_SIGNAL_RESET, 32'd0, TYPE_MASK_RESET);
    // zero interval: same key again at once, and with time going backwards
    send_report(pool_addr[1], pool_kind[1], 8'sd20, 3'd0, 1'b0, TIME_MAX, 0);
    send_report(pool_addr[2], pool_kind[2], 8'sd20, 3'd1, 1'b0, 48'd7, 0);

    clock_ms = '0;
    for (int phase = 0; phase < 8; phase++) begin
      wait_until_drained();
      case (phase)
        0: begin min_dbm = -8'sd128; interval = 32'd0;          mask = 8'hFF; end
        1: begin min_dbm = 8'sd127;  interval = INTERVAL_RESET; mask = 8'h01; end
        2: begin min_dbm = -8'sd75;  interval = 32'hFFFF_FFFF;  mask = 8'h80; end
        3: begin min_dbm = 8'sd0;    interval = 32'd1;          mask = 8'h00; end
        default: begin
          min_dbm  = 8'(int'($urandom_range(0, 70)) - 100);
          interval = (phase % 2 == 0) ? $urandom_range(1, 300) : $urandom;
          mask     = 8'($urandom);
        end
      endcase
      configure(min_dbm, interval, mask);
      if (phase == 4 || phase == 6) clock_ms = {16'($urandom), $urandom};
      count = (mask == 8'h00) ? 40 : 170;
      for (int n = 0; n < count; n++) begin
        // now and then hold off until the filter has caught up
        if ($urandom_range(0, 59) == 0) wait_until_drained();
        send_random_report(phase != 5);
      end
    end

    wait_until_drained();
    repeat (2 * DEPTH) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
